// ===== rtl/core/gdel_pkg.sv =====
// shared constants, types and codes of the grouped dequantizing embedding lookup
`default_nettype none

package gdel_pkg;

  // table geometry, both powers of two so a table address is {row, column}
  localparam int ROWS       = 1024;
  localparam int MAX_DIM    = 64;
  localparam int ROW_AW     = $clog2(ROWS);
  localparam int COL_AW     = $clog2(MAX_DIM);
  localparam int ADDR_W     = ROW_AW + COL_AW;
  localparam int STORE_DEPTH = ROWS * MAX_DIM;

  // field widths
  localparam int CMD_W      = 2;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 6;
  localparam int WEIGHT_W   = 8;
  localparam int SCALE_W    = 24;
  localparam int ZP_W       = 17;
  localparam int VALUE_W    = 32;
  localparam int PARAM_W    = SCALE_W + ZP_W;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 2;

  // datapath widths
  localparam int DIFF_W     = ZP_W + 1;
  localparam int PROD_W     = DIFF_W + SCALE_W;
  localparam int FRAC_DROP  = 8;
  localparam int RND_W      = PROD_W - FRAC_DROP;

  // output queue, deep enough to cover the pipeline so reads stream at full rate
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CRED_W     = FIFO_AW + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_WEIGHT = 2'd0,
    CMD_WR_PARAM  = 2'd1,
    CMD_LOOKUP    = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM     = 2'd0,
    CFG_GROUP   = 2'd1,
    CFG_WSIGNED = 2'd2,
    CFG_USE_ZP  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_t;

  // travels alongside each table read
  typedef struct packed {
    logic             vld;
    logic [COL_W-1:0] element;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COL_W-1:0]   element;
    logic               last;
  } result_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic              we_weight;
    logic              we_param;
    logic              issue;
    logic [CRED_W-1:0] credit;
  } seq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/groupwise_dequant_embedding_lookup.sv =====
// top level: grouped dequantizing embedding lookup over byte weight tables
// write transactions reach the tables on acceptance; a lookup holds the input side until
// its last element is read, one element read per cycle while the result queue has credit
// results pass ram read, difference, product registers, then one per cycle unless stalled
// a new transaction is accepted once the last element of a lookup has been read
// reset (rst_n low, synchronous) clears control, config and queue; tables keep contents
`default_nettype none

module groupwise_dequant_embedding_lookup (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [gdel_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [gdel_pkg::ROW_W-1:0]        in_row,
  input  wire logic [gdel_pkg::COL_W-1:0]        in_column,
  input  wire logic [gdel_pkg::WEIGHT_W-1:0]     in_weight_byte,
  input  wire logic signed [gdel_pkg::SCALE_W-1:0] in_scale,
  input  wire logic signed [gdel_pkg::ZP_W-1:0]  in_zero_point,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [gdel_pkg::VALUE_W-1:0]    out_value,
  output logic      [gdel_pkg::COL_W-1:0]        out_element,
  output logic                                   out_last,
  // configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [gdel_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gdel_pkg::CFG_W-1:0]        cfg_wdata
);

  import gdel_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] dim_r, dim_nxt;
  logic [CFG_W-1:0] gsize_r, gsize_nxt;
  logic             wsigned_r, wsigned_nxt;
  logic             usezp_r, usezp_nxt;

  // table ports
  logic                w_we, p_we;
  logic [ADDR_W-1:0]   w_waddr, p_waddr, w_raddr, p_raddr;
  logic [WEIGHT_W-1:0] w_wdata, w_rdata;
  logic [PARAM_W-1:0]  p_wdata, p_rdata;

  tag_t      tag;
  seq_stat_t stat;
  logic      push, pop, fifo_full;
  result_t   push_data, head;

  assign pop = out_valid && out_ready;

  always_comb begin
    dim_nxt     = dim_r;
    gsize_nxt   = gsize_r;
    wsigned_nxt = wsigned_r;
    usezp_nxt   = usezp_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DIM:     dim_nxt     = cfg_wdata;
        CFG_GROUP:   gsize_nxt   = cfg_wdata;
        CFG_WSIGNED: wsigned_nxt = cfg_wdata[0];
        CFG_USE_ZP:  usezp_nxt   = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r     <= CFG_W'(MAX_DIM);
      gsize_r   <= CFG_W'(MAX_DIM);
      wsigned_r <= 1'b0;
      usezp_r   <= 1'b0;
    end else begin
      dim_r     <= dim_nxt;
      gsize_r   <= gsize_nxt;
      wsigned_r <= wsigned_nxt;
      usezp_r   <= usezp_nxt;
    end
  end

  // sequencer: writes on acceptance, then one read per element while queue credit lasts
  gdel_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_weight_byte (in_weight_byte),
    .in_scale       (in_scale),
    .in_zero_point  (in_zero_point),
    .dim_in_use     (dim_r),
    .grp_len        (gsize_r),
    .pop            (pop),
    .w_we           (w_we),
    .w_waddr        (w_waddr),
    .w_wdata        (w_wdata),
    .p_we           (p_we),
    .p_waddr        (p_waddr),
    .p_wdata        (p_wdata),
    .w_raddr        (w_raddr),
    .p_raddr        (p_raddr),
    .tag            (tag),
    .stat           (stat)
  );

  // weight bytes, addressed {row, column}
  gdel_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (STORE_DEPTH),
    .AW    (ADDR_W)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // group scale and zero point, addressed {row, group}
  gdel_ram #(
    .WIDTH (PARAM_W),
    .DEPTH (STORE_DEPTH),
    .AW    (ADDR_W)
  ) u_param_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // dequantize pipeline, tag is registered alongside the registered ram read
  gdel_dq u_dq (
    .clk             (clk),
    .rst_n           (rst_n),
    .tag_in          (tag),
    .w_rdata         (w_rdata),
    .p_rdata         (p_rdata),
    .weights_signed  (wsigned_r),
    .use_zero_points (usezp_r),
    .push            (push),
    .push_data       (push_data)
  );

  // credit in the sequencer covers pipeline plus queue, so the queue never overflows
  gdel_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (out_valid),
    .full      (fifo_full),
    .head      (head)
  );

  assign out_value   = head.value;
  assign out_element = head.element;
  assign out_last    = head.last;

  // checks

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_full)
    else $error("result queue overflow");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.credit <= CRED_W'(FIFO_DEPTH))
    else $error("credit count above queue depth");

  a_no_write_during_read: assert property (@(posedge clk) disable iff (!rst_n)
    stat.issue |-> !(stat.we_weight || stat.we_param))
    else $error("table write while lookup reads are issued");

  a_ready_low_while_issuing: assert property (@(posedge clk) disable iff (!rst_n)
    stat.issue |-> !in_ready)
    else $error("input accepted during a lookup");

endmodule

`default_nettype wire

// ===== rtl/core/gdel_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
`default_nettype none

module gdel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/gdel_seq.sv =====
// command sequencer: table writes and per-element read address generation
`default_nettype none

module gdel_seq (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [gdel_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [gdel_pkg::ROW_W-1:0]     in_row,
  input  wire logic [gdel_pkg::COL_W-1:0]     in_column,
  input  wire logic [gdel_pkg::WEIGHT_W-1:0]  in_weight_byte,
  input  wire logic [gdel_pkg::SCALE_W-1:0]   in_scale,
  input  wire logic [gdel_pkg::ZP_W-1:0]      in_zero_point,
  input  wire logic [gdel_pkg::CFG_W-1:0]     dim_in_use,
  input  wire logic [gdel_pkg::CFG_W-1:0]     grp_len,
  input  wire logic                           pop,
  output logic                                w_we,
  output logic      [gdel_pkg::ADDR_W-1:0]    w_waddr,
  output logic      [gdel_pkg::WEIGHT_W-1:0]  w_wdata,
  output logic                                p_we,
  output logic      [gdel_pkg::ADDR_W-1:0]    p_waddr,
  output logic      [gdel_pkg::PARAM_W-1:0]   p_wdata,
  output logic      [gdel_pkg::ADDR_W-1:0]    w_raddr,
  output logic      [gdel_pkg::ADDR_W-1:0]    p_raddr,
  output gdel_pkg::tag_t                      tag,
  output gdel_pkg::seq_stat_t                 stat
);

  import gdel_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [ROW_AW-1:0] row_r, row_nxt;
  logic [COL_W-1:0]  j_r, j_nxt;
  logic [COL_W-1:0]  g_r, g_nxt;
  logic [CFG_W-1:0]  ing_r, ing_nxt;
  logic [CFG_W-1:0]  gs_r, gs_nxt;
  logic [COL_W-1:0]  last_idx_r, last_idx_nxt;
  logic [CRED_W-1:0] credit_r, credit_nxt;
  logic              accept, issue, col_ok, is_last;
  logic [CFG_W-1:0]  n_clamped;
  cmd_t              cmd;

  assign cmd     = cmd_t'(in_cmd);
  assign in_ready = rst_n && (state_r == SEQ_IDLE);
  assign accept  = in_valid && in_ready;
  assign issue   = (state_r == SEQ_RUN) && (credit_r < CRED_W'(FIFO_DEPTH));
  assign col_ok  = ({1'b0, in_column} < (COL_W + 1)'(MAX_DIM));
  assign is_last = (j_r == last_idx_r);

  // writes go straight to the tables on acceptance
  assign w_waddr = {in_row[ROW_AW-1:0], in_column[COL_AW-1:0]};
  assign p_waddr = {in_row[ROW_AW-1:0], in_column[COL_AW-1:0]};
  assign w_wdata = in_weight_byte;
  assign p_wdata = {in_scale, in_zero_point};
  assign w_we    = accept && (cmd == CMD_WR_WEIGHT) && col_ok;
  assign p_we    = accept && (cmd == CMD_WR_PARAM) && col_ok;

  assign w_raddr = {row_r, j_r[COL_AW-1:0]};
  assign p_raddr = {row_r, g_r[COL_AW-1:0]};

  assign tag.vld     = issue;
  assign tag.element = j_r;
  assign tag.last    = is_last;

  assign stat.we_weight = w_we;
  assign stat.we_param  = p_we;
  assign stat.issue     = issue;
  assign stat.credit    = credit_r;

  always_comb begin
    if (dim_in_use == '0) begin
      n_clamped = CFG_W'(1);
    end else if (dim_in_use > CFG_W'(MAX_DIM)) begin
      n_clamped = CFG_W'(MAX_DIM);
    end else begin
      n_clamped = dim_in_use;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    j_nxt        = j_r;
    g_nxt        = g_r;
    ing_nxt      = ing_r;
    gs_nxt       = gs_r;
    last_idx_nxt = last_idx_r;
    credit_nxt   = credit_r + CRED_W'(issue) - CRED_W'(pop);
    unique case (state_r)
      SEQ_IDLE: begin
        if (accept && (cmd == CMD_LOOKUP)) begin
          state_nxt    = SEQ_RUN;
          row_nxt      = in_row[ROW_AW-1:0];
          j_nxt        = '0;
          g_nxt        = '0;
          ing_nxt      = '0;
          gs_nxt       = (grp_len == '0) ? CFG_W'(1) : grp_len;
          last_idx_nxt = COL_W'(n_clamped - CFG_W'(1));
        end
      end
      SEQ_RUN: begin
        if (issue) begin
          j_nxt = j_r + COL_W'(1);
          if (ing_r + CFG_W'(1) == gs_r) begin
            ing_nxt = '0;
            g_nxt   = g_r + COL_W'(1);
          end else begin
            ing_nxt = ing_r + CFG_W'(1);
          end
          if (is_last) begin
            state_nxt = SEQ_IDLE;
          end
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SEQ_IDLE;
      credit_r <= '0;
    end else begin
      state_r  <= state_nxt;
      credit_r <= credit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    j_r        <= j_nxt;
    g_r        <= g_nxt;
    ing_r      <= ing_nxt;
    gs_r       <= gs_nxt;
    last_idx_r <= last_idx_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/gdel_dq.sv =====
// dequantize pipeline: difference, multiply, round and saturate
`default_nettype none

module gdel_dq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gdel_pkg::tag_t                tag_in,
  input  wire logic [gdel_pkg::WEIGHT_W-1:0] w_rdata,
  input  wire logic [gdel_pkg::PARAM_W-1:0]  p_rdata,
  input  wire logic                          weights_signed,
  input  wire logic                          use_zero_points,
  output logic                               push,
  output gdel_pkg::result_t                  push_data
);

  import gdel_pkg::*;

  tag_t                      tag1_r, tag2_r, tag3_r;
  logic signed [DIFF_W-1:0]  diff_nxt, diff_r;
  logic signed [SCALE_W-1:0] scale_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  rsum;
  logic signed [RND_W-1:0]   rsh;
  logic signed [ZP_W-1:0]    wsh;
  logic signed [ZP_W-1:0]    zp;
  logic [VALUE_W-1:0]        sat;
  logic                      fits;

  // weight in Q.8 and zero point, both 17 bits signed
  always_comb begin
    wsh      = {weights_signed & w_rdata[WEIGHT_W-1], w_rdata, 8'd0};
    zp       = use_zero_points ? p_rdata[ZP_W-1:0] : '0;
    diff_nxt = {wsh[ZP_W-1], wsh} - {zp[ZP_W-1], zp};
  end

  // ties away from zero: add 128, or 127 for negative products, then shift
  always_comb begin
    rsum = prod_r + (prod_r[PROD_W-1] ? PROD_W'(127) : PROD_W'(128));
    rsh  = RND_W'(rsum >>> FRAC_DROP);
    fits = (rsh[RND_W-1:VALUE_W-1] == '0) || (rsh[RND_W-1:VALUE_W-1] == '1);
    if (fits) begin
      sat = rsh[VALUE_W-1:0];
    end else if (rsh[RND_W-1]) begin
      sat = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  assign push              = tag3_r.vld;
  assign push_data.value   = sat;
  assign push_data.element = tag3_r.element;
  assign push_data.last    = tag3_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    diff_r  <= diff_nxt;
    scale_r <= p_rdata[PARAM_W-1:ZP_W];
    prod_r  <= diff_r * scale_r;
  end

endmodule

`default_nettype wire

// ===== rtl/core/gdel_ofifo.sv =====
// result queue between the pipeline and the output channel
`default_nettype none

module gdel_ofifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire gdel_pkg::result_t push_data,
  input  wire logic              pop,
  output logic                   not_empty,
  output logic                   full,
  output gdel_pkg::result_t      head
);

  import gdel_pkg::*;

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CRED_W-1:0]  count_r;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CRED_W'(FIFO_DEPTH));
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      count_r <= count_r + CRED_W'(push) - CRED_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== bench/groupwise_dequant_embedding_lookup_tb.sv =====
// self-checking testbench for the grouped dequantizing embedding lookup
`timescale 1ns / 1ps

module groupwise_dequant_embedding_lookup_tb;
  import gdel_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 8;
  // worst case is far below this: every lookup 64 elements, every element stalled
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_ITEMS  = 400;
  localparam int EPOCH_ITEMS   = 40;
  // margin for the last accepted writes to land and any extra results to show
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 100_000;
  localparam int TOUCHED_MAX   = 24;

  localparam longint VALUE_MAX = 64'sd2147483647;
  localparam longint VALUE_MIN = -VALUE_MAX - 1;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [CMD_W-1:0]           in_cmd;
  logic [ROW_W-1:0]           in_row;
  logic [COL_W-1:0]           in_column;
  logic [WEIGHT_W-1:0]        in_weight_byte;
  logic signed [SCALE_W-1:0]  in_scale;
  logic signed [ZP_W-1:0]     in_zero_point;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [VALUE_W-1:0]  out_value;
  logic [COL_W-1:0]           out_element;
  logic                       out_last;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_wdata;

  groupwise_dequant_embedding_lookup dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_weight_byte (in_weight_byte),
    .in_scale       (in_scale),
    .in_zero_point  (in_zero_point),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_element    (out_element),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // shadow copy of the tables, addressed row * MAX_DIM + column (or group)
  logic [WEIGHT_W-1:0]       weight_mem  [STORE_DEPTH];
  logic signed [SCALE_W-1:0] scale_mem   [STORE_DEPTH];
  logic signed [ZP_W-1:0]    zp_mem      [STORE_DEPTH];
  // entries known to be written, so a lookup never reads an undefined entry
  bit                        weight_known[STORE_DEPTH];
  bit                        param_known [STORE_DEPTH];

  // shadow copy of the config registers, reset values
  int unsigned dim_reg    = 64;
  int unsigned group_reg  = 64;
  bit          signed_reg = 1'b0;
  bit          use_zp_reg = 1'b0;

  result_t     expected_elements[$];
  logic [ROW_W-1:0] touched_rows[$];
  int          error_count   = 0;
  int          items_sent    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("groupwise_dequant_embedding_lookup_tb: errors");
    $finish;
  end

  // receiver backpressure, redrawn every cycle
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // out-of-range register values are clamped by the block
  function automatic int effective_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > MAX_DIM) return MAX_DIM;
    return dim_reg;
  endfunction

  function automatic int effective_group();
    return (group_reg == 0) ? 1 : group_reg;
  endfunction

  // (weight - zero point) * scale, Q.24 product rounded half away from zero
  // to Q15.16, then saturated to 32 bits
  function automatic logic [VALUE_W-1:0] dequantize_element(
      input logic [WEIGHT_W-1:0]     wbyte,
      input logic signed [SCALE_W-1:0] scale,
      input logic signed [ZP_W-1:0]  zp);
    longint w, diff, prod, rounded;
    w = signed_reg ? longint'($signed(wbyte)) : longint'(wbyte);
    diff = w * 256 - longint'(zp);
    prod = diff * longint'(scale);
    if (prod >= 0) rounded = (prod + 128) >>> 8;
    else rounded = -((-prod + 128) >>> 8);
    if (rounded > VALUE_MAX) rounded = VALUE_MAX;
    if (rounded < VALUE_MIN) rounded = VALUE_MIN;
    return rounded[VALUE_W-1:0];
  endfunction

  // queues one expected element per column; the group advances every
  // group-size elements, counted the way the block counts it
  task automatic predict_row_lookup(input logic [ROW_W-1:0] row);
    int n, gsz, grp, in_grp, base;
    result_t r;
    logic signed [ZP_W-1:0] zp;
    n = effective_dim();
    gsz = effective_group();
    grp = 0;
    in_grp = 0;
    base = int'(row) * MAX_DIM;
    for (int j = 0; j < n; j++) begin
      zp = use_zp_reg ? zp_mem[base + grp] : '0;
      r.value = dequantize_element(weight_mem[base + j], scale_mem[base + grp], zp);
      r.element = COL_W'(j);
      r.last = (j == n - 1);
      expected_elements.push_back(r);
      in_grp++;
      if (in_grp == gsz) begin
        in_grp = 0;
        grp++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_elements.size() == 0) begin
        $error("unexpected element: value %0d element %0d last %0b",
               out_value, out_element, out_last);
        error_count++;
      end else begin
        exp_r = expected_elements.pop_front();
        if (out_value !== exp_r.value) begin
          $error("out_value mismatch: expected %0d, actual %0d",
                 $signed(exp_r.value), out_value);
          error_count++;
        end
        if (out_element !== exp_r.element) begin
          $error("out_element mismatch: expected %0d, actual %0d",
                 exp_r.element, out_element);
          error_count++;
        end
        if (out_last !== exp_r.last) begin
          $error("out_last mismatch: expected %0b, actual %0b", exp_r.last, out_last);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one input transaction; returns right after the accepting edge, the shadow
  // tables and expectations are updated at that point
  task automatic send_item(input cmd_t cmd, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col,
                           input logic [WEIGHT_W-1:0] wbyte,
                           input logic signed [SCALE_W-1:0] scale,
                           input logic signed [ZP_W-1:0] zp);
    int addr;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_cmd         = cmd;
    in_row         = row;
    in_column      = col;
    in_weight_byte = wbyte;
    in_scale       = scale;
    in_zero_point  = zp;
    do @(posedge clk); while (!in_ready);
    addr = int'(row) * MAX_DIM + int'(col);
    case (cmd)
      CMD_WR_WEIGHT: begin
        weight_mem[addr]   = wbyte;
        weight_known[addr] = 1'b1;
      end
      CMD_WR_PARAM: begin
        scale_mem[addr]   = scale;
        zp_mem[addr]      = zp;
        param_known[addr] = 1'b1;
      end
      CMD_LOOKUP: predict_row_lookup(row);
      default: ;
    endcase
    // the unused command is ignored by the block and does not count
    if (cmd != CMD_NOP) items_sent++;
  endtask

  // wait for every expected element plus the write latency before touching config
  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_elements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_DIM:     dim_reg    = 32'(data);
      CFG_GROUP:   group_reg  = 32'(data);
      CFG_WSIGNED: signed_reg = data[0];
      CFG_USE_ZP:  use_zp_reg = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int dim, input int gsz, input bit sgn, input bit use_zp);
    wait_quiet();
    write_cfg(CFG_DIM, CFG_W'(dim));
    write_cfg(CFG_GROUP, CFG_W'(gsz));
    // upper data bits are don't-care on the flag registers
    write_cfg(CFG_WSIGNED, {CFG_W'($urandom) & ~CFG_W'(1)} | CFG_W'(sgn));
    write_cfg(CFG_USE_ZP, {CFG_W'($urandom) & ~CFG_W'(1)} | CFG_W'(use_zp));
  endtask

  // random field values, leaning on the extremes now and then
  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [SCALE_W-1:0] pick_scale();
    case ($urandom_range(11))
      0: return {1'b0, {(SCALE_W-1){1'b1}}};
      1: return {1'b1, {(SCALE_W-1){1'b0}}};
      2: return '0;
      3: return SCALE_W'(128);
      4: return '1;
      default: return SCALE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [ZP_W-1:0] pick_zp();
    case ($urandom_range(9))
      0: return {1'b0, {(ZP_W-1){1'b1}}};
      1: return {1'b1, {(ZP_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return ZP_W'($urandom);
    endcase
  endfunction

  task automatic write_weight(input logic [ROW_W-1:0] row, input int col,
                              input logic [WEIGHT_W-1:0] wbyte);
    // scale and zero point lines carry junk on a weight write
    send_item(CMD_WR_WEIGHT, row, COL_W'(col), wbyte, SCALE_W'($urandom), ZP_W'($urandom));
  endtask

  task automatic write_param(input logic [ROW_W-1:0] row, input int grp,
                             input logic signed [SCALE_W-1:0] scale,
                             input logic signed [ZP_W-1:0] zp);
    send_item(CMD_WR_PARAM, row, COL_W'(grp), WEIGHT_W'($urandom), scale, zp);
  endtask

  task automatic lookup(input logic [ROW_W-1:0] row);
    send_item(CMD_LOOKUP, row, COL_W'($urandom), WEIGHT_W'($urandom),
              SCALE_W'($urandom), ZP_W'($urandom));
  endtask

  // fill whatever the current config will read in this row (rewriting some of
  // the entries already there), then look it up
  task automatic fill_and_lookup(input logic [ROW_W-1:0] row, input int rewrite_pct);
    int n, last_grp, base;
    n = effective_dim();
    last_grp = (n - 1) / effective_group();
    base = int'(row) * MAX_DIM;
    for (int c = 0; c < n; c++)
      if (!weight_known[base + c] || $urandom_range(99) < rewrite_pct)
        write_weight(row, c, pick_weight());
    for (int g = 0; g <= last_grp; g++)
      if (!param_known[base + g] || $urandom_range(99) < rewrite_pct)
        write_param(row, g, pick_scale(), pick_zp());
    lookup(row);
    touched_rows.push_back(row);
    if (touched_rows.size() > TOUCHED_MAX) void'(touched_rows.pop_front());
  endtask

  // random config, mostly small rows so that filling them stays cheap
  task automatic choose_random_config();
    int dim, dim_eff, gsz, pick;
    case ($urandom_range(15))
      0: dim = 0;
      1: dim = 127;
      2: dim = MAX_DIM;
      3: dim = 1;
      default: dim = $urandom_range(2, 8);
    endcase
    dim_eff = (dim == 0) ? 1 : ((dim > MAX_DIM) ? MAX_DIM : dim);
    pick = $urandom_range(11);
    if (pick == 0) gsz = 0;
    else if (pick == 1) gsz = 127;
    else if (pick == 2) gsz = 1;
    else if (pick < 8) begin
      // a divisor of the row length, the usual setup
      do gsz = $urandom_range(1, dim_eff); while (dim_eff % gsz != 0);
    end else gsz = $urandom_range(1, dim_eff);
    // a full row split in single-element groups would cost 128 writes
    if (dim_eff == MAX_DIM && gsz < 4 && pick > 2) gsz = MAX_DIM;
    set_config(dim, gsz, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // unsigned weights with zero points hit both saturation limits
  task automatic test_saturation_unsigned();
    set_config(2, 1, 1'b0, 1'b1);
    write_weight(10'd0, 0, 8'hFF);
    write_weight(10'd0, 1, 8'h00);
    write_param(10'd0, 0, {1'b0, {(SCALE_W-1){1'b1}}}, {1'b1, {(ZP_W-1){1'b0}}});
    write_param(10'd0, 1, {1'b1, {(SCALE_W-1){1'b0}}}, {1'b1, {(ZP_W-1){1'b0}}});
    lookup(10'd0);
  endtask

  // signed weight extremes in the last row of the table
  task automatic test_signed_extremes();
    set_config(2, 1, 1'b1, 1'b1);
    write_weight(10'd1023, 0, 8'h80);
    write_weight(10'd1023, 1, 8'h7F);
    write_param(10'd1023, 0, {1'b0, {(SCALE_W-1){1'b1}}}, {1'b0, {(ZP_W-1){1'b1}}});
    write_param(10'd1023, 1, SCALE_W'(1), '0);
    lookup(10'd1023);
  endtask

  // products exactly half an lsb off, positive and negative
  task automatic test_rounding_ties();
    set_config(2, 1, 1'b0, 1'b1);
    write_weight(10'd2, 0, 8'h00);
    write_weight(10'd2, 1, 8'h00);
    write_param(10'd2, 0, SCALE_W'(128), '1);
    write_param(10'd2, 1, SCALE_W'(128), ZP_W'(1));
    lookup(10'd2);
  endtask

  // zero row length and zero group size both clamp to one; zero points off
  task automatic test_clamped_sizes();
    set_config(0, 0, 1'b0, 1'b0);
    lookup(10'd0);
  endtask

  // the unused command must leave the tables alone and produce nothing
  task automatic test_unused_command();
    send_item(CMD_NOP, 10'd0, 6'd0, 8'h00, '1, '1);
    lookup(10'd0);
  endtask

  // group size that does not divide the row length
  task automatic test_uneven_groups();
    set_config(3, 2, 1'b1, 1'b0);
    for (int c = 0; c < 3; c++) write_weight(10'd5, c, pick_weight());
    write_param(10'd5, 0, pick_scale(), pick_zp());
    write_param(10'd5, 1, pick_scale(), pick_zp());
    lookup(10'd5);
  endtask

  // mostly well-formed fill-then-lookup sequences, some lookups of rows
  // already filled, plus stray writes and unused commands as noise
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int dim, input int gsz,
                                     input bit sgn, input bit use_zp, input int items);
    int start, epoch_start, pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_config(dim, gsz, sgn, use_zp);
    start = items_sent;
    while (items_sent - start < items) begin
      epoch_start = items_sent;
      while (items_sent - epoch_start < EPOCH_ITEMS && items_sent - start < items) begin
        pick = $urandom_range(99);
        if (pick < 55 || touched_rows.size() == 0)
          fill_and_lookup(ROW_W'($urandom), 100);
        else if (pick < 80)
          fill_and_lookup(touched_rows[$urandom_range(touched_rows.size() - 1)], 10);
        else if (pick < 88)
          write_weight(ROW_W'($urandom), $urandom_range(MAX_DIM - 1), pick_weight());
        else if (pick < 95)
          write_param(ROW_W'($urandom), $urandom_range(MAX_DIM - 1), pick_scale(), pick_zp());
        else
          send_item(CMD_NOP, ROW_W'($urandom), COL_W'($urandom), WEIGHT_W'($urandom),
                    SCALE_W'($urandom), ZP_W'($urandom));
      end
      if (items_sent - start < items) choose_random_config();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int drained;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CMD_NOP;
    in_row         = '0;
    in_column      = '0;
    in_weight_byte = '0;
    in_scale       = '0;
    in_zero_point  = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_DIM;
    cfg_wdata      = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // first stretch: sender rarely idles, receiver often stalls
    send_idle_pct = 16;
    recv_idle_pct = 64;
    test_saturation_unsigned();
    test_signed_extremes();
    test_rounding_ties();
    test_clamped_sizes();
    test_unused_command();
    test_uneven_groups();

    // each stretch opens on an extreme config
    test_random_traffic(16, 64, MAX_DIM, MAX_DIM, 1'b0, 1'b0, RANDOM_ITEMS / 3);
    test_random_traffic(64, 16, 127, 127, 1'b1, 1'b1, RANDOM_ITEMS / 3);
    test_random_traffic(0, 0, MAX_DIM, 1, 1'b1, 1'b0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    // drain, then give the block time to show anything extra
    @(negedge clk);
    in_valid = 1'b0;
    drained = 0;
    while (expected_elements.size() != 0 && drained < DRAIN_LIMIT) begin
      @(posedge clk);
      drained++;
    end
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (expected_elements.size() != 0) begin
      $error("%0d expected elements never arrived", expected_elements.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("groupwise_dequant_embedding_lookup_tb: clean");
    end else begin
      $display("groupwise_dequant_embedding_lookup_tb: errors");
    end
    $finish;
  end

endmodule
